[src/crc8_frame_receiver_unit_defines.svh]
// Assertion macros shared by the frame receiver RTL.
`ifndef CRC8_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define CRC8_FRAME_RECEIVER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CRC8FR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CRC8FR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/crc8fr_pkg.sv]
`timescale 1ns / 1ps

package crc8fr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 64;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;
    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_INIT  = 8'h00;

    // CRC-8, MSB first, no reflection and no final XOR, over one byte.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[src/crc8_frame_receiver_unit.sv]
`timescale 1ns / 1ps
`include "crc8_frame_receiver_unit_defines.svh"

// Framed byte receiver: hunts for sync byte 0xAA, then takes a type byte, a
// 16-bit length (low byte first), the payload and a CRC-8 byte (polynomial
// 0x07, initial value 0, over the payload only). Payload bytes are written
// into a synchronous buffer of MAX_PAYLOAD bytes as they arrive,
// so the slave side takes one byte per cycle while a frame is being received.
// When the CRC byte matches, the frame is replayed from the buffer as a run of
// transactions with tlast on the final one; an empty frame gives a single
// transaction with has_payload low. Bad frames and frames longer than the
// buffer are discarded without output. Replaying a frame reads the buffer
// once per cycle while the master side does not stall, and the slave side is
// held off from the CRC byte until the last read byte has moved on to the
// output register; the CRC byte of every frame is taken only once the output
// register is free.
module crc8_frame_receiver_unit #(
    parameter int unsigned MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEF,
    localparam int unsigned LW  = $clog2(MAX_PAYLOAD + 1),
    localparam int unsigned AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int unsigned TDW = ((16 + LW + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    // Slave side
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [7:0]     i_s_axis_tdata,   // [7:0] rx_byte
    // Master side
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [TDW-1:0] o_m_axis_tdata,   // [7:0] frame_type, [15:8] payload_byte,
                                             // [16+LW-1:16] payload_length, rest zero
    output logic           o_m_axis_tuser,   // [0] has_payload
    output logic           o_m_axis_tlast    // last
);

    typedef enum logic [2:0] {
        ST_SYNC,
        ST_TYPE,
        ST_LEN_LO,
        ST_LEN_HI,
        ST_BODY,
        ST_CRC,
        ST_DRAIN
    } t_state;

    t_state       r_state, n_state;
    logic [7:0]   r_kind, n_kind;
    logic [7:0]   r_len_lo, n_len_lo;
    logic [LW-1:0] r_exp_len, n_exp_len;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [7:0]   r_crc, n_crc;
    logic [LW-1:0] r_rd_idx, n_rd_idx;

    // Payload buffer and its registered read port.
    logic [7:0]   r_mem [MAX_PAYLOAD];
    logic [7:0]   r_mem_q;
    logic         r_q_vld, n_q_vld;
    logic         r_q_last, n_q_last;

    // Output register.
    logic         r_out_valid, n_out_valid;
    logic [7:0]   r_out_kind, n_out_kind;
    logic [7:0]   r_out_byte, n_out_byte;
    logic [LW-1:0] r_out_len, n_out_len;
    logic         r_out_has, n_out_has;
    logic         r_out_last, n_out_last;

    logic         in_acc;
    logic         q_move;
    logic         rd_issue;
    logic         mem_we;
    logic [15:0]  full_len;
    logic [LW-1:0] cnt_inc;
    logic [LW-1:0] rd_inc;
    logic [7:0]   rx;

    assign rx = i_s_axis_tdata;

    // The slave side is held while a frame is replayed, and the CRC byte waits
    // for a free output register so that an empty frame always has a slot.
    assign o_s_axis_tready = (r_state != ST_DRAIN) && !r_q_vld
                             && ((r_state != ST_CRC) || !r_out_valid);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign q_move   = r_q_vld && (!r_out_valid || i_m_axis_tready);
    assign rd_issue = (r_state == ST_DRAIN) && (!r_q_vld || q_move);
    assign mem_we   = in_acc && (r_state == ST_BODY);
    assign full_len = {rx, r_len_lo};
    assign cnt_inc  = r_cnt + LW'(1);
    assign rd_inc   = r_rd_idx + LW'(1);

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_len_lo    = r_len_lo;
        n_exp_len   = r_exp_len;
        n_cnt       = r_cnt;
        n_crc       = r_crc;
        n_rd_idx    = r_rd_idx;
        n_q_vld     = r_q_vld;
        n_q_last    = r_q_last;
        n_out_valid = r_out_valid;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_len   = r_out_len;
        n_out_has   = r_out_has;
        n_out_last  = r_out_last;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        if (q_move) begin
            n_q_vld     = 1'b0;
            n_out_valid = 1'b1;
            n_out_kind  = r_kind;
            n_out_byte  = r_mem_q;
            n_out_len   = r_exp_len;
            n_out_has   = 1'b1;
            n_out_last  = r_q_last;
        end

        if (rd_issue) begin
            n_q_vld  = 1'b1;
            n_q_last = (rd_inc == r_exp_len);
            n_rd_idx = rd_inc;
            if (rd_inc == r_exp_len) begin
                n_state = ST_SYNC;
            end
        end

        if (in_acc) begin
            unique case (r_state)
                ST_TYPE: begin
                    n_kind  = rx;
                    n_state = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    n_len_lo = rx;
                    n_state  = ST_LEN_HI;
                end
                ST_LEN_HI: begin
                    n_exp_len = full_len[LW-1:0];
                    n_cnt     = '0;
                    n_crc     = crc8fr_pkg::CRC_INIT;
                    if (full_len > 16'(MAX_PAYLOAD)) begin
                        n_state = ST_SYNC;
                    end else if (full_len == 16'd0) begin
                        n_state = ST_CRC;
                    end else begin
                        n_state = ST_BODY;
                    end
                end
                ST_BODY: begin
                    n_cnt = cnt_inc;
                    n_crc = crc8fr_pkg::crc8_update(r_crc, rx);
                    if (cnt_inc == r_exp_len) begin
                        n_state = ST_CRC;
                    end
                end
                ST_CRC: begin
                    n_state = ST_SYNC;
                    if (rx == r_crc) begin
                        if (r_exp_len == '0) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = r_kind;
                            n_out_byte  = 8'd0;
                            n_out_len   = '0;
                            n_out_has   = 1'b0;
                            n_out_last  = 1'b1;
                        end else begin
                            n_rd_idx = '0;
                            n_state  = ST_DRAIN;
                        end
                    end
                end
                default: begin
                    n_state = (rx == crc8fr_pkg::SYNC_BYTE) ? ST_TYPE : ST_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SYNC;
            r_kind      <= '0;
            r_len_lo    <= '0;
            r_exp_len   <= '0;
            r_cnt       <= '0;
            r_crc       <= '0;
            r_rd_idx    <= '0;
            r_q_vld     <= 1'b0;
            r_q_last    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_len_lo    <= n_len_lo;
            r_exp_len   <= n_exp_len;
            r_cnt       <= n_cnt;
            r_crc       <= n_crc;
            r_rd_idx    <= n_rd_idx;
            r_q_vld     <= n_q_vld;
            r_q_last    <= n_q_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_byte <= n_out_byte;
        r_out_len  <= n_out_len;
        r_out_has  <= n_out_has;
        r_out_last <= n_out_last;
    end

    // Buffer write port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_cnt[AW-1:0]] <= rx;
        end
    end

    // Buffer read port: the data only moves on a new read, so a stalled
    // entry keeps its byte until the output register takes it.
    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_mem_q <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(TDW - 16 - LW)'(0), r_out_len, r_out_byte, r_out_kind};
    assign o_m_axis_tuser  = r_out_has;
    assign o_m_axis_tlast  = r_out_last;

    `CRC8FR_ASSERT_NOW(a_no_input_in_drain, in_acc, (r_state != ST_DRAIN) && !r_q_vld, "byte taken during replay")
    `CRC8FR_ASSERT_NOW(a_read_in_range, rd_issue, r_rd_idx < r_exp_len, "buffer read beyond frame length")
    `CRC8FR_ASSERT_NOW(a_crc_needs_slot, in_acc && (r_state == ST_CRC), !r_out_valid, "CRC byte taken with output busy")
    `CRC8FR_ASSERT_NEXT(a_read_data_held, r_q_vld && !q_move, r_q_vld && $stable(r_mem_q), "buffered read data lost")

endmodule

[tb/sv/tb_crc8_frame_receiver_unit.sv]
`timescale 1ns / 1ps

module tb_crc8_frame_receiver_unit;

    localparam int unsigned MAXP       = crc8fr_pkg::MAX_PAYLOAD_DEF;
    localparam int unsigned STUCK_MAX  = 2000;
    localparam int unsigned DRAIN_WAIT = 20;

    typedef enum logic [2:0] {
        SEEK_SYNC  = 3'd0,
        GET_TYPE   = 3'd1,
        GET_LEN_LO = 3'd2,
        GET_LEN_HI = 3'd3,
        GET_BODY   = 3'd4,
        GET_CHECK  = 3'd5
    } t_rx_phase;

    typedef struct packed {
        logic [7:0] kind;
        logic [7:0] data;
        logic [6:0] len;
        logic       has;
        logic       last;
    } t_beat;

    // Tracks the receiver's framing state and holds the beats still owed by a good frame.
    class frame_scoreboard;
        t_rx_phase   phase = SEEK_SYNC;
        logic [7:0]  kind = 8'h00;
        logic [15:0] announced = 16'h0000;
        int unsigned got = 0;
        logic [7:0]  crc = crc8fr_pkg::CRC_INIT;
        logic [7:0]  body [MAXP];
        t_beat       owed [$];
        int unsigned errors = 0;

        // Bit-serial form of the CRC-8 update, one data bit at a time, MSB first.
        static function logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = acc;
            for (int i = 7; i >= 0; i--) begin
                fb = r[7] ^ b[i];
                r  = {r[6:0], 1'b0} ^ (fb ? crc8fr_pkg::CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function void take_byte(input logic [7:0] b);
            case (phase)
                GET_TYPE: begin
                    kind  = b;
                    phase = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    announced = {8'h00, b};
                    phase     = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    announced[15:8] = b;
                    got = 0;
                    crc = crc8fr_pkg::CRC_INIT;
                    if (announced > MAXP) begin
                        phase = SEEK_SYNC;
                    end else if (announced == 0) begin
                        phase = GET_CHECK;
                    end else begin
                        phase = GET_BODY;
                    end
                end
                GET_BODY: begin
                    if (got < MAXP) body[got] = b;
                    got++;
                    crc = crc_byte(crc, b);
                    if (got >= announced) phase = GET_CHECK;
                end
                GET_CHECK: begin
                    if (b == crc) begin
                        if (announced == 0) begin
                            owed.push_back('{kind, 8'h00, 7'd0, 1'b0, 1'b1});
                        end else begin
                            for (int i = 0; i < announced; i++) begin
                                owed.push_back('{kind, body[i], announced[6:0], 1'b1,
                                                 (i + 1 == announced)});
                            end
                        end
                    end
                    phase = SEEK_SYNC;
                end
                default: begin
                    phase = (b == crc8fr_pkg::SYNC_BYTE) ? GET_TYPE : SEEK_SYNC;
                end
            endcase
        endfunction

        function void check_beat(input t_beat seen);
            t_beat want;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: unexpected transaction type=%02h byte=%02h len=%0d has=%0b last=%0b",
                             $realtime, seen.kind, seen.data, seen.len, seen.has, seen.last);
                end
                return;
            end
            want = owed.pop_front();
            if (want !== seen) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch exp type=%02h byte=%02h len=%0d has=%0b last=%0b",
                             $realtime, want.kind, want.data, want.len, want.has, want.last);
                    $display("%0t:          got type=%02h byte=%02h len=%0d has=%0b last=%0b",
                             $realtime, seen.kind, seen.data, seen.len, seen.has, seen.last);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = 8'h00;   // [7:0] rx_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;           // [7:0] frame_type, [15:8] payload_byte,
                                           // [22:16] payload_length, [23] zero
    logic        o_m_axis_tuser;           // [0] has_payload
    logic        o_m_axis_tlast;

    frame_scoreboard sb = new;
    int unsigned     src_idle_pct = 0;
    int unsigned     sink_stall_pct = 0;
    int unsigned     bytes_sent = 0;
    int unsigned     stuck_cycles = 0;

    crc8_frame_receiver_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_beat('{o_m_axis_tdata[7:0], o_m_axis_tdata[15:8],
                            o_m_axis_tdata[22:16], o_m_axis_tuser, o_m_axis_tlast});
        end
    end

    // Nothing moving on either side for too long means the receiver has hung.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_MAX) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.take_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // An announced length above the buffer size sends the header only.
    task automatic send_frame(input logic [7:0] kind, input logic [7:0] body[$],
                              input logic [15:0] announced, input bit spoil);
        logic [7:0] crc;
        crc = crc8fr_pkg::CRC_INIT;
        send_byte(crc8fr_pkg::SYNC_BYTE);
        send_byte(kind);
        send_byte(announced[7:0]);
        send_byte(announced[15:8]);
        if (announced <= MAXP) begin
            foreach (body[i]) begin
                send_byte(body[i]);
                crc = frame_scoreboard::crc_byte(crc, body[i]);
            end
            send_byte(spoil ? crc ^ 8'($urandom_range(1, 255)) : crc);
        end
    endtask

    task automatic random_traffic(input int unsigned byte_goal);
        logic [7:0]  body[$];
        logic [15:0] announced;
        int unsigned sel;
        int unsigned n;
        byte_goal += bytes_sent;
        while (bytes_sent < byte_goal) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end else if (sel < 14) begin
                case ($urandom_range(3))
                    0: announced = 16'hFFFF;
                    1: announced = 16'(MAXP + 1);
                    default: announced = 16'($urandom_range(MAXP + 1, 16'hFFFF));
                endcase
                body = {};
                send_frame(8'($urandom_range(255)), body, announced, 1'b0);
            end else begin
                n = $urandom_range(99);
                if (n < 10) begin
                    n = 0;
                end else if (n < 13) begin
                    n = MAXP;
                end else if (n < 75) begin
                    n = $urandom_range(1, 8);
                end else begin
                    n = $urandom_range(9, MAXP - 1);
                end
                body = {};
                repeat (n) body.push_back(8'($urandom_range(255)));
                send_frame(8'($urandom_range(255)), body, 16'(n), sel < 26);
            end
        end
    endtask

    initial begin
        logic [7:0] body[$];
        logic [7:0] crc;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct   = 19;
        sink_stall_pct = 84;

        // Noise while hunting, then an empty frame with its zero CRC and a one-byte frame.
        send_byte(8'h00);
        send_byte(8'hFF);
        body = {};
        send_frame(8'hFF, body, 16'd0, 1'b0);
        body = {8'hFF};
        send_frame(8'h00, body, 16'd1, 1'b0);

        // Bad CRC that happens to be the sync byte: it must not start a frame.
        send_byte(crc8fr_pkg::SYNC_BYTE);
        send_byte(8'h12);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_byte(8'h55);
        crc = frame_scoreboard::crc_byte(frame_scoreboard::crc_byte(crc8fr_pkg::CRC_INIT,
                                                                    8'hAA), 8'h55);
        send_byte((crc == crc8fr_pkg::SYNC_BYTE) ? 8'h00 : crc8fr_pkg::SYNC_BYTE);

        // One byte too long, then a frame straight after the dropped header.
        body = {};
        send_frame(8'h34, body, 16'(MAXP + 1), 1'b0);
        send_frame(8'h01, body, 16'd0, 1'b0);

        random_traffic(120);

        src_idle_pct   = 84;
        sink_stall_pct = 19;
        random_traffic(120);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        random_traffic(120);

        i_s_axis_tvalid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
